/* sv/motor_speed_to_hbridge_pwm_defines.svh */
// ----------------------------------------------------------------------------
// motor_speed_to_hbridge_pwm assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_TO_HBRIDGE_PWM_DEFINES_SVH
`define MOTOR_SPEED_TO_HBRIDGE_PWM_DEFINES_SVH

// same-cycle implication
`define MSHB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSHB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mshb_pkg.sv */
// ----------------------------------------------------------------------------
// mshb_pkg
// shared types and constants of the motor speed to h-bridge pwm block
// ----------------------------------------------------------------------------
`default_nettype none

package mshb_pkg;

  // config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MIN_SPEED  = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

  // reset values
  localparam logic [9:0]  MIN_SPEED_RST  = 10'd10;
  localparam logic [9:0]  MAX_SPEED_RST  = 10'd300;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd999;

  // rpm per rad/s in q16
  localparam logic [19:0] RPM_PER_RAD_Q16 = 20'd625822;

  // 100 percent in q8.8
  localparam logic [14:0] PCT_FULL_Q8 = 15'd25600;

  // floor(2^30 / 100) for the compare scaling
  localparam logic [23:0] RECIP_100   = 24'd10737418;
  localparam logic [6:0]  HUNDRED     = 7'd100;

  // calibration coefficients, index {side, backward}
  localparam logic [13:0] COEF_A [4] = '{14'd13312, 14'd13184, 14'd13466, 14'd13568};
  localparam logic [14:0] COEF_B [4] = '{15'd20316, 15'd21928, 15'd23003, 15'd20972};
  localparam logic [20:0] COEF_C [4] =
    '{21'd1529008, 21'd1632088, 21'd545461, 21'd1374390};

  // live configuration handed to the datapath
  typedef struct packed {
    logic [9:0]  min_speed_rpm;
    logic [9:0]  max_speed_rpm;
    logic [15:0] pwm_period;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/motor_speed_to_hbridge_pwm.sv */
// ----------------------------------------------------------------------------
// motor_speed_to_hbridge_pwm
// wheel velocity command to h-bridge compare values with deadband brake
// ----------------------------------------------------------------------------
// A command (side, signed q8.8 rad/s) is taken on any cycle with start high;
// busy is always low, so one command per clock is sustained. Each command
// gives exactly one result beat on out_strobe, from an eight-register
// pipeline whose depth is set by the calibration multiplies (rpm, r squared,
// split c*r^2 partial products) and the reciprocal divide by 25600. The
// receiver cannot stall: out_strobe is high for one cycle and the result must
// be captured then. The user must write registers over the apb port only
// while no command is in flight; the block itself does not enforce this.
`default_nettype none

module motor_speed_to_hbridge_pwm
  import mshb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic               in_motor_side,
  input  logic signed [15:0] in_angular_velocity,
  // result channel
  output logic               out_strobe,
  output logic [15:0]        out_forward_compare,
  output logic [15:0]        out_backward_compare,
  output logic               out_brake_active,
  output logic signed [15:0] out_duty_percent,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  logic accept;

  // fully pipelined, never busy
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  mshb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mshb_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (accept),
    .in_side    (in_motor_side),
    .in_vel     (in_angular_velocity),
    .out_strobe (out_strobe),
    .out_fwd    (out_forward_compare),
    .out_bwd    (out_backward_compare),
    .out_brake  (out_brake_active),
    .out_duty   (out_duty_percent)
  );

endmodule

`default_nettype wire

/* sv/mshb_cfg.sv */
// ----------------------------------------------------------------------------
// mshb_cfg
// apb register file holding min speed, max speed and pwm period
// ----------------------------------------------------------------------------
`default_nettype none

module mshb_cfg
  import mshb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [9:0]  min_speed_r, min_speed_nxt;
  logic [9:0]  max_speed_r, max_speed_nxt;
  logic [15:0] period_r, period_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // write decode
  always_comb begin
    min_speed_nxt = min_speed_r;
    max_speed_nxt = max_speed_r;
    period_nxt    = period_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MIN_SPEED:  min_speed_nxt = pwdata[9:0];
        REG_MAX_SPEED:  max_speed_nxt = pwdata[9:0];
        REG_PWM_PERIOD: period_nxt    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= MIN_SPEED_RST;
      max_speed_r <= MAX_SPEED_RST;
      period_r    <= PWM_PERIOD_RST;
    end else begin
      min_speed_r <= min_speed_nxt;
      max_speed_r <= max_speed_nxt;
      period_r    <= period_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MIN_SPEED:  prdata = {22'd0, min_speed_r};
      REG_MAX_SPEED:  prdata = {22'd0, max_speed_r};
      REG_PWM_PERIOD: prdata = {16'd0, period_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.min_speed_rpm = min_speed_r;
  assign cfg.max_speed_rpm = max_speed_r;
  assign cfg.pwm_period    = period_r;

endmodule

`default_nettype wire

/* sv/mshb_pipe.sv */
// ----------------------------------------------------------------------------
// mshb_pipe
// eight-stage datapath: rpm conversion, deadband, quadratic calibration,
// compare scaling
// ----------------------------------------------------------------------------
`default_nettype none
`include "motor_speed_to_hbridge_pwm_defines.svh"

module mshb_pipe
  import mshb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic               in_side,
  input  logic signed [15:0] in_vel,
  output logic               out_strobe,
  output logic [15:0]        out_fwd,
  output logic [15:0]        out_bwd,
  output logic               out_brake,
  output logic signed [15:0] out_duty
);

  // valid bits, one per stage 1 to 7
  logic [6:0] v_r;

  // stage 1: |w| to rpm q8
  logic        bwd1_nxt;
  logic [15:0] mag1;
  logic [35:0] rpm_prod;
  logic [18:0] r1_nxt;
  logic        side1_r, bwd1_r;
  logic [18:0] r1_r;

  // stage 2: deadband and clamp
  logic        brake2_nxt;
  logic [17:0] lim2;
  logic [17:0] rc2_nxt;
  logic [1:0]  idx2_r;
  logic        brake2_r;
  logic [17:0] rc2_r;

  // stage 3: r^2 and b*r
  logic [1:0]  idx3_r;
  logic        brake3_r;
  logic [35:0] rsq3_r;
  logic [32:0] br3_r;

  // stage 4: c*r^2 partial products, constant and linear terms
  logic [1:0]  idx4_r;
  logic        brake4_r;
  logic [38:0] pplo4_r, pphi4_r;
  logic [59:0] ab4_r, ab4_nxt;

  // stage 5: final sum, round, saturate
  logic [59:0] sum5;
  logic [19:0] pfull5;
  logic [14:0] p5_nxt;
  logic        bwd5_r, brake5_r;
  logic [14:0] p5_r;

  // stage 6: period * p
  logic        bwd6_r, brake6_r;
  logic [14:0] p6_r;
  logic [30:0] x6_r;

  // stage 7: reciprocal estimate of (x >> 8) / 100
  logic [22:0] y7_nxt;
  logic [46:0] qprod7;
  logic        bwd7_r, brake7_r;
  logic [14:0] p7_r;
  logic [22:0] y7_r;
  logic [16:0] q7_r;

  // output stage: remainder correction and channel select
  logic [23:0] q100;
  logic [23:0] rem8;
  logic [16:0] cmp8;
  logic [15:0] cmp16;
  logic        out_strobe_r;
  logic [15:0] out_fwd_r, out_bwd_r;
  logic        out_brake_r;
  logic [15:0] out_duty_r;

  // stage 1 logic
  assign bwd1_nxt = in_vel[15];
  assign mag1     = bwd1_nxt ? (~in_vel + 16'd1) : in_vel;
  assign rpm_prod = 36'(mag1) * 36'(RPM_PER_RAD_Q16);
  assign r1_nxt   = 19'((rpm_prod + 36'h8000) >> 16);

  // stage 2 logic
  assign brake2_nxt = r1_r < {1'b0, cfg.min_speed_rpm, 8'd0};
  assign lim2       = {cfg.max_speed_rpm, 8'd0};
  assign rc2_nxt    = (r1_r > {1'b0, lim2}) ? lim2 : r1_r[17:0];

  // stage 4 logic: constant plus linear term plus rounding half
  assign ab4_nxt = (60'(COEF_A[idx3_r]) << 40) + (60'(br3_r) << 24) + (60'd1 << 39);

  // stage 5 logic
  assign sum5   = ab4_r + 60'(pplo4_r) + (60'(pphi4_r) << 18);
  assign pfull5 = sum5[59:40];
  assign p5_nxt = (pfull5 > 20'(PCT_FULL_Q8)) ? PCT_FULL_Q8 : pfull5[14:0];

  // stage 7 logic
  assign y7_nxt = x6_r[30:8];
  assign qprod7 = 47'(y7_nxt) * 47'(RECIP_100);

  // output stage logic
  assign q100  = 24'(q7_r) * 24'(HUNDRED);
  assign rem8  = 24'(y7_r) - q100;
  assign cmp8  = (rem8 >= 24'(HUNDRED)) ? (q7_r + 17'd1) : q7_r;
  assign cmp16 = cmp8[16] ? 16'hFFFF : cmp8[15:0];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      v_r          <= {v_r[5:0], in_valid};
      out_strobe_r <= v_r[6];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    side1_r  <= in_side;
    bwd1_r   <= bwd1_nxt;
    r1_r     <= r1_nxt;

    idx2_r   <= {side1_r, bwd1_r};
    brake2_r <= brake2_nxt;
    rc2_r    <= rc2_nxt;

    idx3_r   <= idx2_r;
    brake3_r <= brake2_r;
    rsq3_r   <= 36'(rc2_r) * 36'(rc2_r);
    br3_r    <= 33'(COEF_B[idx2_r]) * 33'(rc2_r);

    idx4_r   <= idx3_r;
    brake4_r <= brake3_r;
    pplo4_r  <= 39'(COEF_C[idx3_r]) * 39'(rsq3_r[17:0]);
    pphi4_r  <= 39'(COEF_C[idx3_r]) * 39'(rsq3_r[35:18]);
    ab4_r    <= ab4_nxt;

    bwd5_r   <= idx4_r[0];
    brake5_r <= brake4_r;
    p5_r     <= p5_nxt;

    bwd6_r   <= bwd5_r;
    brake6_r <= brake5_r;
    p6_r     <= p5_r;
    x6_r     <= 31'(cfg.pwm_period) * 31'(p5_r);

    bwd7_r   <= bwd6_r;
    brake7_r <= brake6_r;
    p7_r     <= p6_r;
    y7_r     <= y7_nxt;
    q7_r     <= qprod7[46:30];

    // channel select
    out_brake_r <= brake7_r;
    if (brake7_r) begin
      out_fwd_r  <= cfg.pwm_period;
      out_bwd_r  <= cfg.pwm_period;
      out_duty_r <= '0;
    end else if (bwd7_r) begin
      out_fwd_r  <= '0;
      out_bwd_r  <= cmp16;
      out_duty_r <= 16'd0 - {1'b0, p7_r};
    end else begin
      out_fwd_r  <= cmp16;
      out_bwd_r  <= '0;
      out_duty_r <= {1'b0, p7_r};
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_fwd    = out_fwd_r;
  assign out_bwd    = out_bwd_r;
  assign out_brake  = out_brake_r;
  assign out_duty   = out_duty_r;

  // checks
  `MSHB_ASSERT_NXT(a_valid_moves, v_r[0], v_r[1], "stage valid lost between stage 1 and 2")
  `MSHB_ASSERT_IMP(a_brake_out, out_strobe && out_brake,
    out_duty == 16'sd0 && out_fwd == out_bwd, "brake beat with drive payload")
  `MSHB_ASSERT_IMP(a_one_channel, out_strobe && !out_brake,
    out_fwd == 16'd0 || out_bwd == 16'd0, "both channels driven")
  `MSHB_ASSERT_IMP(a_duty_range, out_strobe,
    out_duty <= 16'sd25600 && out_duty >= -16'sd25600, "duty out of range")

endmodule

`default_nettype wire
